### rtl/llas_pkg.sv
// Shared constants and types for the life-like automaton step unit.
// No dependencies; imported by every module under rtl/.
package llas_pkg;

	localparam int MAX_COLS = 64;
	localparam int MAX_ROWS = 64;
	localparam int ROW_IW   = $clog2(MAX_ROWS);
	localparam int DIM_W    = 7;
	localparam int MASK_W   = 9;
	localparam int CNT_W    = 4;
	localparam int IDX_W    = 2;

	localparam logic [1:0] FUNC_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	localparam logic [IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_BIRTH   = 2'd2;
	localparam logic [IDX_W-1:0] REG_SURVIVE = 2'd3;

	typedef logic [MAX_COLS-1:0] row_t;

	typedef struct packed {
		logic [MASK_W-1:0] birth;
		logic [MASK_W-1:0] survive;
	} rule_cfg_t;

endpackage

### rtl/llas_row_cell.sv
// One cell of the row chain: holds one board row, takes its neighbor's row on shift.
// Depends on llas_pkg.
module llas_row_cell
	import llas_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  row_t row_in,
	output row_t row_out
);

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift_en) begin
			row_q <= row_in;
		end
	end

	assign row_out = row_q;

endmodule

### rtl/llas_row_rule.sv
// Next-generation row from three old rows: per-column neighbor count and mask lookup.
// Depends on llas_pkg. Rows arrive with out-of-grid bits already cleared.
module llas_row_rule
	import llas_pkg::*;
(
	input  row_t      above,
	input  row_t      mid,
	input  row_t      below,
	input  rule_cfg_t rule_cfg,
	output row_t      next_row
);

	logic [MAX_COLS+1:0] above_p, mid_p, below_p;
	logic [CNT_W-1:0]    cnt [MAX_COLS];

	assign above_p = {1'b0, above, 1'b0};
	assign mid_p   = {1'b0, mid, 1'b0};
	assign below_p = {1'b0, below, 1'b0};

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			cnt[c] = CNT_W'(above_p[c]) + CNT_W'(above_p[c+1]) + CNT_W'(above_p[c+2])
				+ CNT_W'(mid_p[c]) + CNT_W'(mid_p[c+2])
				+ CNT_W'(below_p[c]) + CNT_W'(below_p[c+1]) + CNT_W'(below_p[c+2]);
			next_row[c] = mid[c] ? rule_cfg.survive[cnt[c]] : rule_cfg.birth[cnt[c]];
		end
	end

endmodule

### rtl/life_like_automaton_step_unit.sv
// Life-like automaton step unit: 64x64 one-bit board held in a rotating chain of row cells.
// Every item (write, advance, read) rotates the chain once through all 64 row cells, then hands
// the result to the output register, which waits while a held result is not taken; m_tvalid
// is set in the same cycle that s_tready returns, so one item is in flight at a time.
// An advance computes one new row per shift cycle from a three-row window at the chain head.
// arst_n clears the board, control state and the output; registers take B3/S23 on 64x64.
// Depends on llas_pkg, llas_row_cell, llas_row_rule.
module life_like_automaton_step_unit
	import llas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // func[1:0], col[7:2], row[13:8], cell_in[14], zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // cell_out[0], outside_grid[1], zero
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_addr,
	input  logic [MASK_W-1:0] cfg_wdata
);

	localparam logic [ROW_IW-1:0] LAST_STEP = ROW_IW'(MAX_ROWS - 1);

	logic [DIM_W-1:0] grid_width_q, grid_height_q;
	rule_cfg_t        rule_q;

	logic              busy_q, pend_q;
	logic [ROW_IW-1:0] step_q;
	logic [1:0]        func_q;
	logic [5:0]        col_q, row_q;
	logic              val_q, outside_q;
	logic              res_cell_q, res_flag_q;
	logic              out_valid_q, out_cell_q, out_flag_q;
	row_t              prev_q;

	logic [DIM_W-1:0] eff_w, eff_h;
	logic [1:0]       in_func;
	logic [5:0]       in_col, in_row;
	logic             in_outside, accept, hit_row;
	row_t             col_mask, head, below, above_m, mid_m, below_m, rule_row, upd_mask;
	row_t             tail_row, wr_row;
	row_t             rows [MAX_ROWS];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= DIM_W'(MAX_COLS);
			grid_height_q <= DIM_W'(MAX_ROWS);
			rule_q.birth   <= MASK_W'(8);
			rule_q.survive <= MASK_W'(12);
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WIDTH:   grid_width_q   <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT:  grid_height_q  <= cfg_wdata[DIM_W-1:0];
				REG_BIRTH:   rule_q.birth   <= cfg_wdata;
				REG_SURVIVE: rule_q.survive <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign eff_w = (grid_width_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_q;
	assign eff_h = (grid_height_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_q;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = DIM_W'(c) < eff_w;
		end
	end

	assign in_func    = s_tdata[1:0];
	assign in_col     = s_tdata[7:2];
	assign in_row     = s_tdata[13:8];
	assign in_outside = ({1'b0, in_col} >= eff_w) || ({1'b0, in_row} >= eff_h);

	assign s_tready = !busy_q && !pend_q;
	assign accept   = s_tvalid && s_tready;

	// row chain: rows[0] is the head, the tail takes the processed head row
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		if (i == MAX_ROWS - 1) begin : g_tail
			llas_row_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(busy_q),
				.row_in  (tail_row),
				.row_out (rows[i])
			);
		end else begin : g_body
			llas_row_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(busy_q),
				.row_in  (rows[i+1]),
				.row_out (rows[i])
			);
		end
	end

	assign head  = rows[0];
	assign below = rows[1];

	// neighbors outside the grid in use count as dead
	assign above_m  = (step_q == '0) ? '0 : (prev_q & col_mask);
	assign mid_m    = head & col_mask;
	assign below_m  = ({1'b0, step_q} + DIM_W'(1) < eff_h) ? (below & col_mask) : '0;
	assign upd_mask = ({1'b0, step_q} < eff_h) ? col_mask : '0;

	llas_row_rule u_rule (
		.above   (above_m),
		.mid     (mid_m),
		.below   (below_m),
		.rule_cfg(rule_q),
		.next_row(rule_row)
	);

	assign hit_row = (step_q == row_q[ROW_IW-1:0]) && !outside_q;

	always_comb begin
		wr_row = head;
		wr_row[col_q] = val_q;
		case (func_q)
			FUNC_ADVANCE: tail_row = (rule_row & upd_mask) | (head & ~upd_mask);
			FUNC_WRITE:   tail_row = hit_row ? wr_row : head;
			default:      tail_row = head;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + ROW_IW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					pend_q <= 1'b1;
				end
			end else if (pend_q && (!out_valid_q || m_tready)) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= in_func;
			col_q      <= in_col;
			row_q      <= in_row;
			val_q      <= s_tdata[14];
			outside_q  <= in_outside;
			res_cell_q <= 1'b0;
			res_flag_q <= in_outside && (in_func == FUNC_WRITE || in_func == FUNC_READ);
		end else if (busy_q) begin
			prev_q <= head;
			if (func_q == FUNC_READ && hit_row) begin
				res_cell_q <= head[col_q];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_cell_q  <= 1'b0;
			out_flag_q  <= 1'b0;
		end else if (pend_q && !busy_q && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
			out_cell_q  <= res_cell_q;
			out_flag_q  <= res_flag_q;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_flag_q, out_cell_q};

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && pend_q))
		else $error("busy and pending result at once");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && step_q == '0))
		else $error("accepted item did not start a rotation");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == LAST_STEP) |=> (!busy_q && pend_q))
		else $error("rotation did not end after the last row");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("cell value reported for an outside address");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for life_like_automaton_step_unit: cell writes, reads and generation
// steps under several grid sizes and rules, checked against a board predictor in a small class.
// Depends on rtl/llas_pkg.sv and rtl/life_like_automaton_step_unit.sv.
module testbench
	import llas_pkg::*;
();

	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int TARGET_ITEMS = 550;
	localparam int MAX_GAP      = 18;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 80;

	typedef struct packed {
		logic cell_out;
		logic outside_grid;
	} cell_result_t;

	class life_board_scoreboard;
		row_t board [MAX_ROWS];
		logic [DIM_W-1:0] cols_cfg;
		logic [DIM_W-1:0] rows_cfg;
		logic [MASK_W-1:0] birth_cfg;
		logic [MASK_W-1:0] survive_cfg;
		cell_result_t expected_cells [$];
		int mismatches;

		function new();
			foreach (board[i]) board[i] = '0;
			cols_cfg = 64;
			rows_cfg = 64;
			birth_cfg = 8;
			survive_cfg = 12;
			mismatches = 0;
		endfunction

		function int cols_in_use();
			return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
		endfunction

		function int rows_in_use();
			return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
		endfunction

		function int pending();
			return expected_cells.size();
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [MASK_W-1:0] value);
			case (idx)
				REG_WIDTH:   cols_cfg = value[DIM_W-1:0];
				REG_HEIGHT:  rows_cfg = value[DIM_W-1:0];
				REG_BIRTH:   birth_cfg = value;
				REG_SURVIVE: survive_cfg = value;
				default: ;
			endcase
		endfunction

		// All cells update from the old board; neighbors beyond the border are dead.
		function void step_generation();
			row_t fresh [MAX_ROWS];
			logic [MASK_W-1:0] rule;
			int w, h, n, rr, cc;
			w = cols_in_use();
			h = rows_in_use();
			fresh = board;
			for (int r = 0; r < h; r++) begin
				for (int c = 0; c < w; c++) begin
					n = 0;
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							rr = r + dr;
							cc = c + dc;
							if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < h && cc < w)
								n += board[rr][cc];
						end
					end
					rule = board[r][c] ? survive_cfg : birth_cfg;
					fresh[r][c] = rule[n];
				end
			end
			board = fresh;
		endfunction

		function void note_item(logic [1:0] func, logic [5:0] col, logic [5:0] row,
				logic cell_in);
			cell_result_t res;
			logic outside;
			outside = (int'(col) >= cols_in_use()) || (int'(row) >= rows_in_use());
			res = '0;
			case (func)
				FUNC_WRITE: begin
					if (outside)
						res.outside_grid = 1'b1;
					else
						board[row][col] = cell_in;
				end
				FUNC_ADVANCE: step_generation();
				FUNC_READ: begin
					if (outside)
						res.outside_grid = 1'b1;
					else
						res.cell_out = board[row][col];
				end
				default: ;
			endcase
			expected_cells = {expected_cells, res};
		endfunction

		function void check_result(cell_result_t got);
			cell_result_t want;
			if (expected_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: cell_out=%0b outside_grid=%0b",
						got.cell_out, got.outside_grid);
				return;
			end
			want = expected_cells.pop_front();
			if (got.cell_out !== want.cell_out || got.outside_grid !== want.outside_grid) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected cell_out=%0b outside_grid=%0b, got %0b %0b",
						want.cell_out, want.outside_grid, got.cell_out, got.outside_grid);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;   // func[1:0], col[7:2], row[13:8], cell_in[14], zero
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;    // cell_out[0], outside_grid[1], zero
	logic cfg_we;
	logic [IDX_W-1:0] cfg_addr;
	logic [MASK_W-1:0] cfg_wdata;

	life_board_scoreboard boards;
	int items_sent = 0;
	int results_seen = 0;
	int cycles = 0;
	bit send_burst = 0;
	bit recv_burst = 0;
	bit hold_done = 0;

	life_like_automaton_step_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(logic [1:0] func, logic [5:0] col, logic [5:0] row,
			logic cell_in);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, cell_in, row, col, func};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		boards.note_item(func, col, row, cell_in);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int pick, w, h;
		logic [1:0] func;
		logic [5:0] col, row;
		w = boards.cols_in_use();
		h = boards.rows_in_use();
		pick = $urandom_range(0, 99);
		if (pick < 45)
			func = FUNC_WRITE;
		else if (pick < 58)
			func = FUNC_ADVANCE;
		else if (pick < 95)
			func = FUNC_READ;
		else
			func = FUNC_NONE;
		if (w == 0 || h == 0 || $urandom_range(0, 9) == 0) begin
			col = 6'($urandom_range(0, 63));
			row = 6'($urandom_range(0, 63));
		end else begin
			col = 6'($urandom_range(0, w - 1));
			row = 6'($urandom_range(0, h - 1));
		end
		send_item(func, col, row, 1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (boards.pending() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [MASK_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		boards.set_reg(idx, value);
	endtask

	task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [MASK_W-1:0] birth, logic [MASK_W-1:0] survive);
		write_reg(REG_WIDTH, {2'b00, w});
		write_reg(REG_HEIGHT, {2'b00, h});
		write_reg(REG_BIRTH, birth);
		write_reg(REG_SURVIVE, survive);
		cfg_we <= 1'b0;
	endtask

	task automatic configure_random();
		int pick;
		logic [DIM_W-1:0] w, h;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			w = DIM_W'($urandom_range(3, 10));
			h = DIM_W'($urandom_range(3, 10));
		end else if (pick < 9) begin
			w = DIM_W'($urandom_range(1, 64));
			h = DIM_W'($urandom_range(1, 64));
		end else begin
			w = DIM_W'($urandom_range(0, 127));
			h = DIM_W'($urandom_range(0, 127));
		end
		configure(w, h, MASK_W'($urandom_range(0, 511)), MASK_W'($urandom_range(0, 511)));
	endtask

	// Result side: random stalls, one long hold-off so the block backs up its input.
	initial begin
		int gap;
		cell_result_t got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (!hold_done && results_seen >= 60) begin
				gap += LONG_HOLD;
				hold_done = 1;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got.cell_out = m_tdata[0];
			got.outside_grid = m_tdata[1];
			boards.check_result(got);
			results_seen++;
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		boards = new();
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset rule B3/S23 on 64x64: corners, blinker, overwrite with dead, unused func
		send_item(FUNC_READ, 0, 0, 0);
		send_item(FUNC_WRITE, 0, 0, 1);
		send_item(FUNC_WRITE, 63, 63, 1);
		send_item(FUNC_WRITE, 10, 10, 1);
		send_item(FUNC_WRITE, 11, 10, 1);
		send_item(FUNC_WRITE, 12, 10, 1);
		send_item(FUNC_ADVANCE, 0, 0, 0);
		send_item(FUNC_READ, 11, 9, 0);
		send_item(FUNC_READ, 11, 11, 0);
		send_item(FUNC_READ, 10, 10, 0);
		send_item(FUNC_READ, 63, 63, 0);
		send_item(FUNC_WRITE, 11, 10, 0);
		send_item(FUNC_READ, 11, 10, 0);
		send_item(FUNC_NONE, 63, 63, 1);
		repeat (80) send_random_item();
		// lone cell outside the smaller grids to come; must survive them
		send_item(FUNC_WRITE, 40, 40, 1);
		drain();

		// every count births, nothing survives
		configure(8, 8, 9'h1FF, 9'h000);
		send_item(FUNC_ADVANCE, 0, 0, 0);
		send_item(FUNC_READ, 7, 7, 0);
		send_item(FUNC_READ, 8, 0, 0);
		send_item(FUNC_WRITE, 0, 8, 1);
		send_item(FUNC_ADVANCE, 0, 0, 0);
		send_item(FUNC_READ, 3, 3, 0);
		repeat (30) send_random_item();
		drain();

		// zero-sized grid
		configure(0, 0, 9'h1FF, 9'h1FF);
		send_item(FUNC_WRITE, 0, 0, 1);
		send_item(FUNC_READ, 0, 0, 0);
		send_item(FUNC_ADVANCE, 0, 0, 0);
		send_item(FUNC_NONE, 0, 0, 0);
		repeat (10) send_random_item();
		drain();

		// oversized dimensions clamp to the full board
		configure(127, 127, 9'd8, 9'd12);
		send_item(FUNC_READ, 40, 40, 0);
		send_item(FUNC_READ, 63, 63, 0);
		repeat (40) send_random_item();
		drain();

		configure(1, 1, 9'h000, 9'h1FF);
		repeat (20) send_random_item();
		drain();
		configure(64, 3, MASK_W'($urandom_range(0, 511)), MASK_W'($urandom_range(0, 511)));
		repeat (40) send_random_item();
		drain();
		configure(3, 64, MASK_W'($urandom_range(0, 511)), MASK_W'($urandom_range(0, 511)));
		repeat (40) send_random_item();

		while (items_sent < TARGET_ITEMS) begin
			drain();
			configure_random();
			repeat ($urandom_range(25, 60)) send_random_item();
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (boards.mismatches == 0 && boards.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
